### src/fwlg_pkg.sv
// ----------------------------------------------------------------------------
// fwlg_pkg
// Shared sizes, row word layout, command codes and register helpers for the
// wall lighting grid.
// ----------------------------------------------------------------------------
package fwlg_pkg;

    localparam int unsigned MAX_COLS = 64;
    localparam int unsigned MAX_ROWS = 64;

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int DIM_W  = 7;
    localparam int WIDE_W = ((COL_W > ROW_W) ? COL_W : ROW_W) + 1;
    // bounds reach col + radius + 1, which needs 8 bits
    localparam int BND_W  = (WIDE_W > 8) ? WIDE_W : 8;

    localparam logic [2:0] CMD_SET_TRANS = 3'd0;
    localparam logic [2:0] CMD_SET_LIT   = 3'd1;
    localparam logic [2:0] CMD_READ      = 3'd2;
    localparam logic [2:0] CMD_CLEAR     = 3'd3;
    localparam logic [2:0] CMD_RUN       = 3'd4;

    localparam logic REG_MAP_WIDTH  = 1'b0;
    localparam logic REG_MAP_HEIGHT = 1'b1;

    // one grid row per memory word
    typedef struct packed {
        logic [MAX_COLS-1:0] lit;
        logic [MAX_COLS-1:0] trans;
    } t_row;

    // clipped window along one axis: viewpoint position and [lo, hi)
    typedef struct packed {
        logic [BND_W-1:0] pos;
        logic [BND_W-1:0] lo;
        logic [BND_W-1:0] hi;
    } t_span;

    // zero reads as one, saturate at the store size
    function automatic logic [DIM_W-1:0] clip_dim(input logic [DIM_W-1:0] v,
                                                  input int unsigned maxv);
        logic [DIM_W-1:0] d;
        d = v;
        if (d == '0) begin
            d = DIM_W'(1);
        end
        if (32'(d) > maxv) begin
            d = DIM_W'(maxv);
        end
        return d;
    endfunction

endpackage

### src/fwlg_ram.sv
// ----------------------------------------------------------------------------
// fwlg_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fwlg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### src/fwlg_row_light.sv
// ----------------------------------------------------------------------------
// fwlg_row_light
// Lights the opaque cells of one row from lit transparent neighbors that lie
// toward the viewpoint: same row, the source row, and its diagonal.
// ----------------------------------------------------------------------------
module fwlg_row_light (
    input  fwlg_pkg::t_row  i_cur,
    input  fwlg_pkg::t_row  i_src,
    input  logic            i_has_src,
    input  fwlg_pkg::t_span i_span,
    output fwlg_pkg::t_row  o_row
);
    import fwlg_pkg::*;

    logic [MAX_COLS-1:0] w_lt;
    logic [MAX_COLS-1:0] w_gt;
    logic [MAX_COLS-1:0] w_win;
    logic [MAX_COLS-1:0] w_sp_cur;
    logic [MAX_COLS-1:0] w_sp_src;
    logic [MAX_COLS-1:0] w_horz;
    logic [MAX_COLS-1:0] w_vert;
    logic [MAX_COLS-1:0] w_diag;

    always_comb begin
        for (int k = 0; k < MAX_COLS; k++) begin
            w_lt[k]  = BND_W'(k) < i_span.pos;
            w_gt[k]  = BND_W'(k) > i_span.pos;
            w_win[k] = (BND_W'(k) >= i_span.lo) && (BND_W'(k) < i_span.hi);
        end
    end

    assign w_sp_cur = i_cur.trans & i_cur.lit;
    assign w_sp_src = i_src.trans & i_src.lit;

    // source sits one column nearer the viewpoint column
    assign w_horz = (w_lt & (w_sp_cur >> 1)) | (w_gt & (w_sp_cur << 1));
    assign w_vert = i_has_src ? w_sp_src : '0;
    assign w_diag = i_has_src ? ((w_lt & (w_sp_src >> 1)) | (w_gt & (w_sp_src << 1))) : '0;

    assign o_row.trans = i_cur.trans;
    assign o_row.lit   = i_cur.lit | (w_win & ~i_cur.trans & (w_horz | w_vert | w_diag));

endmodule

### src/fov_wall_lighting_grid.sv
// ----------------------------------------------------------------------------
// fov_wall_lighting_grid
// Grid of transparent/lit cells with host access and a wall lighting pass.
// ----------------------------------------------------------------------------
// The grid is held one row per word in a single RAM (MAX_ROWS words of
// 2*MAX_COLS bits), so cell writes and runs are read-modify-writes of whole
// rows. Set transparency and set lit read the row, then modify and write it
// back; read cell reads the row and returns the cell. An out-of-map
// coordinate or an unknown command answers without a row access. Clear
// writes every row once. A run reads each row of the clipped window, reads
// its neighbor row toward the viewpoint, then lights the row within the
// window columns and writes it back, so the single RAM read port sets the
// pace. After reset the block sweeps all MAX_ROWS rows to opaque and unlit
// and takes no item until done; configuration writes are taken throughout.
// Only one item is in flight; a finished result waits in the output
// register and the next item may be accepted meanwhile.
// ----------------------------------------------------------------------------
module fov_wall_lighting_grid (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // command word
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [2:0]                   i_cmd,
    input  logic [5:0]                   i_col,
    input  logic [5:0]                   i_row,
    input  logic                         i_transparent_in,
    input  logic                         i_lit_in,
    input  logic [6:0]                   i_radius,
    // result word
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_lit_out,
    output logic                         o_transparent_out,
    output logic                         o_status,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import fwlg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CELL,
        S_RUN_RDT,
        S_RUN_RDS,
        S_RUN_WR,
        S_SWEEP,
        S_RESP
    } t_state;

    t_state           r_state;

    // configuration registers
    logic [DIM_W-1:0] r_map_width;
    logic [DIM_W-1:0] r_map_height;

    // accepted command
    logic [2:0]       r_cmd;
    logic [5:0]       r_col;
    logic [5:0]       r_row;
    logic             r_tin;
    logic             r_lin;

    // run and sweep bookkeeping
    t_span            r_xspan;
    t_span            r_yspan;
    logic [ROW_W-1:0] r_ty;
    t_row             r_cur;
    logic             r_fill;
    logic             r_init;

    // result holding and output registers
    logic             r_res_lit;
    logic             r_res_trans;
    logic             r_res_status;
    logic             r_out_valid;
    logic             r_out_lit;
    logic             r_out_trans;
    logic             r_out_status;

    // RAM port
    logic                   ram_we;
    logic [ROW_W-1:0]       ram_waddr;
    logic [$bits(t_row)-1:0] ram_wdata;
    logic [ROW_W-1:0]       ram_raddr;
    logic [$bits(t_row)-1:0] ram_rdata;

    t_row             w_rd_row;
    t_row             w_cell_row;
    t_row             w_lit_row;
    t_row             w_fill_row;
    logic [COL_W-1:0] w_cidx;
    logic             w_accept;
    logic             w_inside;
    logic             w_cfg_wr;
    logic             w_out_free;
    logic             w_fin;
    logic             n_res_lit;
    logic             n_res_trans;
    logic             n_res_status;
    logic             w_has_src;
    logic [ROW_W-1:0] w_src_row;
    logic             w_run_last;
    logic             w_sweep_last;

    // window bounds, worked out at acceptance
    logic [BND_W-1:0] w_col_b;
    logic [BND_W-1:0] w_row_b;
    logic [BND_W-1:0] w_rad_b;
    logic [BND_W-1:0] w_xend;
    logic [BND_W-1:0] w_yend;
    t_span            w_xspan;
    t_span            w_yspan;

    // ------------------------------------------------------------------
    // Handshakes and configuration port
    // ------------------------------------------------------------------
    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_MAP_HEIGHT) ? 32'(r_map_height) : 32'(r_map_width);

    assign o_valid           = r_out_valid;
    assign o_lit_out         = r_out_lit;
    assign o_transparent_out = r_out_trans;
    assign o_status          = r_out_status;
    assign w_out_free        = !r_out_valid || i_ready;

    assign w_inside = ({1'b0, i_col} < r_map_width) && ({1'b0, i_row} < r_map_height);

    // ------------------------------------------------------------------
    // Clip the square window to the map; radius zero takes the whole map
    // ------------------------------------------------------------------
    assign w_col_b = BND_W'(i_col);
    assign w_row_b = BND_W'(i_row);
    assign w_rad_b = BND_W'(i_radius);
    assign w_xend  = w_col_b + w_rad_b + BND_W'(1);
    assign w_yend  = w_row_b + w_rad_b + BND_W'(1);

    always_comb begin
        w_xspan.pos = w_col_b;
        w_yspan.pos = w_row_b;
        w_xspan.lo  = ((i_radius != '0) && (w_col_b > w_rad_b)) ? (w_col_b - w_rad_b) : '0;
        w_yspan.lo  = ((i_radius != '0) && (w_row_b > w_rad_b)) ? (w_row_b - w_rad_b) : '0;
        w_xspan.hi  = ((i_radius != '0) && (w_xend < BND_W'(r_map_width))) ?
                      w_xend : BND_W'(r_map_width);
        w_yspan.hi  = ((i_radius != '0) && (w_yend < BND_W'(r_map_height))) ?
                      w_yend : BND_W'(r_map_height);
    end

    // ------------------------------------------------------------------
    // Row datapath
    // ------------------------------------------------------------------
    assign w_rd_row = t_row'(ram_rdata);
    assign w_cidx   = COL_W'(r_col);

    // patch one cell of the row just read
    always_comb begin
        w_cell_row = w_rd_row;
        if (r_cmd == CMD_SET_TRANS) begin
            w_cell_row.trans[w_cidx] = r_tin;
        end else if (r_cmd == CMD_SET_LIT) begin
            w_cell_row.lit[w_cidx] = r_lin;
        end
    end

    assign w_fill_row.lit   = '0;
    assign w_fill_row.trans = {MAX_COLS{r_fill}};

    // the source row lies one step toward the viewpoint row
    assign w_has_src    = (BND_W'(r_ty) != r_yspan.pos);
    assign w_src_row    = (BND_W'(r_ty) < r_yspan.pos) ? (r_ty + ROW_W'(1)) :
                          (BND_W'(r_ty) > r_yspan.pos) ? (r_ty - ROW_W'(1)) : r_ty;
    assign w_run_last   = ((BND_W'(r_ty) + BND_W'(1)) == r_yspan.hi);
    assign w_sweep_last = (r_ty == ROW_W'(MAX_ROWS - 1));

    fwlg_row_light u_row_light (
        .i_cur     (r_cur),
        .i_src     (w_rd_row),
        .i_has_src (w_has_src),
        .i_span    (r_xspan),
        .o_row     (w_lit_row)
    );

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_ty;
        ram_wdata = w_fill_row;
        ram_raddr = ROW_W'(i_row);
        unique case (r_state)
            S_IDLE: begin
                ram_raddr = ROW_W'(i_row);
            end
            S_CELL: begin
                ram_we    = (r_cmd == CMD_SET_TRANS) || (r_cmd == CMD_SET_LIT);
                ram_waddr = ROW_W'(r_row);
                ram_wdata = w_cell_row;
            end
            S_RUN_RDT: begin
                ram_raddr = r_ty;
            end
            S_RUN_RDS: begin
                ram_raddr = w_src_row;
            end
            S_RUN_WR: begin
                ram_we    = 1'b1;
                ram_wdata = w_lit_row;
            end
            S_SWEEP: begin
                ram_we    = 1'b1;
                ram_wdata = w_fill_row;
            end
            S_RESP: begin
                ram_raddr = r_ty;
            end
        endcase
    end

    fwlg_ram #(
        .WIDTH ($bits(t_row)),
        .DEPTH (MAX_ROWS)
    ) u_grid_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Result of the step that finishes this cycle
    // ------------------------------------------------------------------
    always_comb begin
        w_fin        = 1'b0;
        n_res_lit    = 1'b0;
        n_res_trans  = 1'b0;
        n_res_status = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if ((i_cmd == CMD_SET_TRANS) || (i_cmd == CMD_SET_LIT) ||
                        (i_cmd == CMD_READ) || (i_cmd == CMD_RUN)) begin
                        // flag a coordinate outside the map, change nothing
                        w_fin        = !w_inside;
                        n_res_status = !w_inside;
                    end else if (i_cmd != CMD_CLEAR) begin
                        // unknown command answers with zeros
                        w_fin = 1'b1;
                    end
                end
            end
            S_CELL: begin
                w_fin = 1'b1;
                if (r_cmd == CMD_READ) begin
                    n_res_lit   = w_rd_row.lit[w_cidx];
                    n_res_trans = w_rd_row.trans[w_cidx];
                end
            end
            S_RUN_WR: begin
                w_fin = w_run_last;
            end
            S_SWEEP: begin
                w_fin = w_sweep_last && !r_init;
            end
            S_RUN_RDT, S_RUN_RDS, S_RESP: begin
                w_fin = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer, configuration and output registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;
            r_ty         <= '0;
            r_fill       <= 1'b0;
            r_init       <= 1'b1;
            r_out_valid  <= 1'b0;
            r_map_width  <= clip_dim(DIM_W'(64), MAX_COLS);
            r_map_height <= clip_dim(DIM_W'(64), MAX_ROWS);
        end else begin
            if (w_cfg_wr) begin
                if (paddr[2] == REG_MAP_HEIGHT) begin
                    r_map_height <= clip_dim(pwdata[DIM_W-1:0], MAX_ROWS);
                end else begin
                    r_map_width <= clip_dim(pwdata[DIM_W-1:0], MAX_COLS);
                end
            end

            // load a finished or a held result once the output frees,
            // else drop the word once taken
            if (w_fin && w_out_free) begin
                r_out_valid  <= 1'b1;
                r_out_lit    <= n_res_lit;
                r_out_trans  <= n_res_trans;
                r_out_status <= n_res_status;
            end else if ((r_state == S_RESP) && w_out_free) begin
                r_out_valid  <= 1'b1;
                r_out_lit    <= r_res_lit;
                r_out_trans  <= r_res_trans;
                r_out_status <= r_res_status;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end

            // hold the result until the output register frees
            if (w_fin && !w_out_free) begin
                r_res_lit    <= n_res_lit;
                r_res_trans  <= n_res_trans;
                r_res_status <= n_res_status;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd <= i_cmd;
                        r_col <= i_col;
                        r_row <= i_row;
                        r_tin <= i_transparent_in;
                        r_lin <= i_lit_in;
                        priority if (w_fin) begin
                            r_state <= w_out_free ? S_IDLE : S_RESP;
                        end else if (i_cmd == CMD_CLEAR) begin
                            r_state <= S_SWEEP;
                            r_ty    <= '0;
                            r_fill  <= i_transparent_in;
                        end else if (i_cmd == CMD_RUN) begin
                            r_state <= S_RUN_RDT;
                            r_xspan <= w_xspan;
                            r_yspan <= w_yspan;
                            r_ty    <= ROW_W'(w_yspan.lo);
                        end else begin
                            r_state <= S_CELL;
                        end
                    end
                end
                S_CELL: begin
                    r_state <= w_out_free ? S_IDLE : S_RESP;
                end
                S_RUN_RDT: begin
                    r_state <= S_RUN_RDS;
                end
                S_RUN_RDS: begin
                    r_cur   <= w_rd_row;
                    r_state <= S_RUN_WR;
                end
                S_RUN_WR: begin
                    if (w_run_last) begin
                        r_state <= w_out_free ? S_IDLE : S_RESP;
                    end else begin
                        r_ty    <= r_ty + ROW_W'(1);
                        r_state <= S_RUN_RDT;
                    end
                end
                S_SWEEP: begin
                    if (w_sweep_last) begin
                        if (r_init) begin
                            // power-up sweep owes no result
                            r_init  <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= w_out_free ? S_IDLE : S_RESP;
                        end
                    end else begin
                        r_ty <= r_ty + ROW_W'(1);
                    end
                end
                S_RESP: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_read_goes_to_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_cmd == CMD_READ) && w_inside) |=> (r_state == S_CELL))
        else $error("in-map read did not start a row access");

    a_run_row_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN_WR) |->
            ((BND_W'(r_ty) >= r_yspan.lo) && (BND_W'(r_ty) < r_yspan.hi)))
        else $error("run row outside the clipped window");

    a_status_clears_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (!o_lit_out && !o_transparent_out))
        else $error("out-of-map result carries cell bits");

    a_src_then_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN_RDS) |=> ((r_state == S_RUN_WR) && $stable(r_ty)))
        else $error("row write does not follow the source read");

endmodule

### tb/fov_wall_lighting_grid_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fov_wall_lighting_grid_tb
// Self-checking bench for the wall lighting grid. A shadow copy of the cell
// store and of the map size predicts every result word. The stimulus is a
// directed opening followed by random scenes. A scene may clear the grid,
// writes cells around a viewpoint, runs the lighting pass and then reads the
// neighborhood back. Scenes are spread over several map sizes, with random
// gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module fov_wall_lighting_grid_tb;

    import fwlg_pkg::*;

    // commands the block ignores
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

    // register i sits at byte address 4*i
    localparam logic [2:0] ADDR_MAP_WIDTH  = {REG_MAP_WIDTH, 2'b00};
    localparam logic [2:0] ADDR_MAP_HEIGHT = {REG_MAP_HEIGHT, 2'b00};

    localparam int RANDOM_WORDS = 1100;
    localparam int DRAIN_CYCLES = 256;   // longer than a full-map run
    localparam int SCENES_PER_SIZE = 5;

    typedef struct packed {
        logic [2:0] cmd;
        logic [5:0] col;
        logic [5:0] row;
        logic       trans;
        logic       lit;
        logic [6:0] radius;
    } t_grid_word;

    typedef struct {
        logic [2:0] cmd;
        logic       lit;
        logic       trans;
        logic       status;
    } t_cell_answer;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_cmd = '0;
    logic [5:0]  i_col = '0;
    logic [5:0]  i_row = '0;
    logic        i_transparent_in = 1'b0;
    logic        i_lit_in = 1'b0;
    logic [6:0]  i_radius = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_lit_out;
    logic        o_transparent_out;
    logic        o_status;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    fov_wall_lighting_grid i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_cmd             (i_cmd),
        .i_col             (i_col),
        .i_row             (i_row),
        .i_transparent_in  (i_transparent_in),
        .i_lit_in          (i_lit_in),
        .i_radius          (i_radius),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_lit_out         (o_lit_out),
        .o_transparent_out (o_transparent_out),
        .o_status          (o_status),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the grid and the map size
    // ------------------------------------------------------------------
    bit shadow_trans [MAX_ROWS][MAX_COLS];
    bit shadow_lit   [MAX_ROWS][MAX_COLS];
    int map_cols = MAX_COLS;
    int map_rows = MAX_ROWS;

    t_grid_word   word_q[$];     // command words waiting for the driver
    t_cell_answer answer_q[$];   // predicted result words, oldest first

    int unsigned words_queued = 0;
    int unsigned results_seen = 0;
    int unsigned errors = 0;
    int unsigned runs_in_map = 0;
    int unsigned lit_reads = 0;
    int unsigned sizes_used = 1;
    bit          no_idle = 1'b0;

    // Register semantics: zero reads as one, saturate at the store size.
    function automatic int fit_dim(logic [31:0] v, int maxv);
        int d;
        d = int'(v[6:0]);
        if (d == 0) begin
            d = 1;
        end
        if (d > maxv) begin
            d = maxv;
        end
        return d;
    endfunction

    function automatic void light_if_opaque(int x, int y);
        if (!shadow_trans[y][x]) begin
            shadow_lit[y][x] = 1'b1;
        end
    endfunction

    // Spread light from every lit transparent cell of the quadrant to its
    // opaque neighbors one step further from the viewpoint. Only opaque cells
    // get lit, so no new source appears and the visiting order is irrelevant.
    function automatic void light_quadrant(int x0, int y0, int x1, int y1, int dx, int dy);
        int  x2;
        int  y2;
        bit  xin;
        bit  yin;
        for (int cx = x0; cx <= x1; cx++) begin
            for (int cy = y0; cy <= y1; cy++) begin
                x2  = cx + dx;
                y2  = cy + dy;
                xin = (x2 >= x0) && (x2 <= x1);
                yin = (y2 >= y0) && (y2 <= y1);
                if (shadow_trans[cy][cx] && shadow_lit[cy][cx]) begin
                    if (xin) light_if_opaque(x2, cy);
                    if (yin) light_if_opaque(cx, y2);
                    if (xin && yin) light_if_opaque(x2, y2);
                end
            end
        end
    endfunction

    // Clip the square window to the map and light the four quadrants that
    // share the viewpoint's row and column.
    function automatic void light_window(int px, int py, int rad);
        int x_min;
        int y_min;
        int x_max;
        int y_max;
        x_min = 0;
        y_min = 0;
        x_max = map_cols;
        y_max = map_rows;
        if (rad > 0) begin
            if (px - rad > x_min) x_min = px - rad;
            if (py - rad > y_min) y_min = py - rad;
            if (px + rad + 1 < x_max) x_max = px + rad + 1;
            if (py + rad + 1 < y_max) y_max = py + rad + 1;
        end
        light_quadrant(x_min, y_min, px, py, -1, -1);
        light_quadrant(px, y_min, x_max - 1, py, 1, -1);
        light_quadrant(x_min, py, px, y_max - 1, -1, 1);
        light_quadrant(px, py, x_max - 1, y_max - 1, 1, 1);
    endfunction

    // Advance the shadow by one command word and return the result word.
    function automatic t_cell_answer apply_grid_word(t_grid_word w);
        t_cell_answer a;
        int           c;
        int           r;
        bit           in_map;
        c      = int'(w.col);
        r      = int'(w.row);
        in_map = (c < map_cols) && (r < map_rows);
        a      = '{w.cmd, 1'b0, 1'b0, 1'b0};
        case (w.cmd)
            CMD_SET_TRANS: begin
                if (in_map) shadow_trans[r][c] = w.trans;
                else a.status = 1'b1;
            end
            CMD_SET_LIT: begin
                if (in_map) shadow_lit[r][c] = w.lit;
                else a.status = 1'b1;
            end
            CMD_READ: begin
                if (in_map) begin
                    a.lit   = shadow_lit[r][c];
                    a.trans = shadow_trans[r][c];
                    if (a.lit) lit_reads++;
                end else begin
                    a.status = 1'b1;
                end
            end
            CMD_CLEAR: begin
                // clear the whole store, also cells outside the map in use
                for (int y = 0; y < MAX_ROWS; y++) begin
                    for (int x = 0; x < MAX_COLS; x++) begin
                        shadow_trans[y][x] = w.trans;
                        shadow_lit[y][x]   = 1'b0;
                    end
                end
            end
            CMD_RUN: begin
                if (in_map) begin
                    light_window(c, r, int'(w.radius));
                    runs_in_map++;
                end else begin
                    a.status = 1'b1;
                end
            end
            default: begin
                // spare codes: no change, all fields zero
            end
        endcase
        return a;
    endfunction

    // ------------------------------------------------------------------
    // Driver: predict on acceptance, then present the next queued word
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_words
        t_grid_word w;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                w = '{i_cmd, i_col, i_row, i_transparent_in, i_lit_in, i_radius};
                answer_q.push_back(apply_grid_word(w));
            end
            // hold the word until accepted; only a free slot may idle
            if (!i_valid || o_ready) begin
                if (word_q.size() != 0 && (no_idle || $urandom_range(99) >= 34)) begin
                    w                = word_q.pop_front();
                    i_valid          <= 1'b1;
                    i_cmd            <= w.cmd;
                    i_col            <= w.col;
                    i_row            <= w.row;
                    i_transparent_in <= w.trans;
                    i_lit_in         <= w.lit;
                    i_radius         <= w.radius;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: stall at random, compare every accepted result word
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_cell_answer a;
        i_ready <= no_idle || ($urandom_range(99) >= 34);
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (answer_q.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0t: result word with none expected (lit %b trans %b status %b)",
                             $realtime, o_lit_out, o_transparent_out, o_status);
                end
            end else begin
                a = answer_q.pop_front();
                if (o_lit_out !== a.lit || o_transparent_out !== a.trans
                        || o_status !== a.status) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("%0t: cmd %0d exp lit %b trans %b status %b, got %b %b %b",
                                 $realtime, a.cmd, a.lit, a.trans, a.status,
                                 o_lit_out, o_transparent_out, o_status);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send(input logic [2:0] cmd, input logic [5:0] col, input logic [5:0] row,
                        input logic t, input logic l, input logic [6:0] rad);
        word_q.push_back('{cmd, col, row, t, l, rad});
        words_queued++;
    endtask

    // Drain: wait until every queued word has produced its result word.
    task automatic settle();
        while (results_seen < words_queued) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    // APB write: setup cycle, access cycle; the register updates at the
    // edge that closes the access cycle.
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_MAP_WIDTH) map_cols = fit_dim(data, MAX_COLS);
        else map_rows = fit_dim(data, MAX_ROWS);
    endtask

    // Coordinate a few cells from a center, clamped to the map; now and then
    // anywhere in the field range, so out-of-map cells show up too.
    function automatic logic [5:0] near_coord(int centre, int limit);
        int v;
        if ($urandom_range(9) == 0) begin
            return 6'($urandom_range(63));
        end
        v = centre + int'($urandom_range(6)) - 3;
        if (v < 0) v = 0;
        if (v > limit - 1) v = limit - 1;
        return 6'(v);
    endfunction

    // One scene: optional clear, cell writes around a viewpoint, a lighting
    // run, read-back of the neighborhood, and a little noise.
    task automatic stage_scene();
        int         vx;
        int         vy;
        logic [6:0] rad;
        if ($urandom_range(1)) begin
            send(CMD_CLEAR, 6'($urandom), 6'($urandom), 1'($urandom), 1'($urandom),
                 7'($urandom));
        end
        vx = $urandom_range(map_cols - 1);
        vy = $urandom_range(map_rows - 1);
        repeat ($urandom_range(10, 4)) begin
            send($urandom_range(1) ? CMD_SET_LIT : CMD_SET_TRANS,
                 near_coord(vx, map_cols), near_coord(vy, map_rows),
                 1'($urandom), 1'($urandom), 7'($urandom));
        end
        case ($urandom_range(9))
            0, 1, 2: rad = '0;
            3, 4, 5, 6: rad = 7'($urandom_range(4, 1));
            default: rad = 7'($urandom_range(127));
        endcase
        // now and then a viewpoint anywhere, possibly off the map
        if ($urandom_range(9) == 0) begin
            send(CMD_RUN, 6'($urandom), 6'($urandom), 1'($urandom), 1'($urandom), rad);
        end else begin
            send(CMD_RUN, 6'(vx), 6'(vy), 1'($urandom), 1'($urandom), rad);
        end
        repeat ($urandom_range(10, 5)) begin
            send(CMD_READ, near_coord(vx, map_cols), near_coord(vy, map_rows),
                 1'($urandom), 1'($urandom), 7'($urandom));
        end
        if ($urandom_range(2) == 0) begin
            send(3'($urandom), 6'($urandom), 6'($urandom), 1'($urandom), 1'($urandom),
                 7'($urandom));
        end
        if ($urandom_range(4) == 0) begin
            send(3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST)), 6'($urandom),
                 6'($urandom), 1'($urandom), 1'($urandom), 7'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : run_sequence
        int size_idx;
        int w_set;
        int h_set;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening at the reset map size of 64 x 64.
        send(CMD_READ, 6'd0, 6'd0, 1'b0, 1'b0, 7'd0);          // reset state
        send(CMD_READ, 6'd63, 6'd63, 1'b1, 1'b1, 7'd127);
        send(CMD_SET_TRANS, 6'd63, 6'd63, 1'b1, 1'b0, 7'd0);
        send(CMD_SET_LIT, 6'd63, 6'd63, 1'b0, 1'b1, 7'd0);
        send(CMD_READ, 6'd63, 6'd63, 1'b0, 1'b0, 7'd0);
        send(CMD_SET_TRANS, 6'd0, 6'd0, 1'b1, 1'b0, 7'd0);
        send(CMD_SET_LIT, 6'd0, 6'd0, 1'b0, 1'b1, 7'd0);
        send(CMD_RUN, 6'd0, 6'd0, 1'b0, 1'b0, 7'd1);            // corner, smallest window
        send(CMD_READ, 6'd1, 6'd1, 1'b0, 1'b0, 7'd0);
        send(CMD_READ, 6'd2, 6'd2, 1'b0, 1'b0, 7'd0);
        send(CMD_RUN, 6'd63, 6'd63, 1'b0, 1'b0, 7'd0);          // whole map
        send(CMD_READ, 6'd62, 6'd62, 1'b0, 1'b0, 7'd0);
        send(CMD_SET_LIT, 6'd62, 6'd62, 1'b0, 1'b0, 7'd0);
        send(CMD_RUN, 6'd63, 6'd63, 1'b1, 1'b1, 7'd127);        // window past the map
        send(CMD_READ, 6'd62, 6'd62, 1'b0, 1'b0, 7'd0);
        send(CMD_SPARE_FIRST, 6'd63, 6'd63, 1'b1, 1'b1, 7'd127);
        send(CMD_SPARE_LAST, 6'd0, 6'd0, 1'b0, 1'b0, 7'd0);
        send(CMD_CLEAR, 6'd5, 6'd5, 1'b1, 1'b1, 7'd3);
        send(CMD_READ, 6'd10, 6'd10, 1'b0, 1'b0, 7'd0);
        send(CMD_CLEAR, 6'd0, 6'd0, 1'b0, 1'b0, 7'd0);
        settle();

        // Shrink the map and probe its right and bottom edges from outside.
        write_reg(ADDR_MAP_WIDTH, 32'd8);
        write_reg(ADDR_MAP_HEIGHT, 32'd8);
        sizes_used++;
        send(CMD_SET_TRANS, 6'd8, 6'd0, 1'b1, 1'b0, 7'd0);
        send(CMD_SET_LIT, 6'd0, 6'd8, 1'b0, 1'b1, 7'd0);
        send(CMD_READ, 6'd63, 6'd63, 1'b0, 1'b0, 7'd0);
        send(CMD_RUN, 6'd8, 6'd7, 1'b0, 1'b0, 7'd2);
        settle();

        // Random scenes over a sequence of map sizes, the extremes and the
        // out-of-range register values among them.
        size_idx = 0;
        while (words_queued < RANDOM_WORDS + 24) begin
            case (size_idx)
                0: begin w_set = 1;   h_set = 1;   end
                1: begin w_set = 64;  h_set = 64;  end
                2: begin w_set = 0;   h_set = 127; end
                3: begin w_set = 127; h_set = 0;   end
                4: begin w_set = 5;   h_set = 12;  end
                5: begin w_set = 64;  h_set = 2;   end
                6: begin w_set = 3;   h_set = 64;  end
                7: begin w_set = 16;  h_set = 16;  end
                default: begin
                    w_set = $urandom_range(127);
                    h_set = $urandom_range(127);
                end
            endcase
            write_reg(ADDR_MAP_WIDTH, 32'(w_set));
            write_reg(ADDR_MAP_HEIGHT, 32'(h_set));
            sizes_used++;
            // one full-size stretch with neither side idling
            no_idle = (size_idx == 1);
            repeat (SCENES_PER_SIZE) stage_scene();
            settle();
            no_idle = 1'b0;
            size_idx++;
        end

        // Catch stray result words after the last expected one.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        errors += answer_q.size();

        $display("Covered %0d command words over %0d map sizes.", words_queued, sizes_used);
        $display("Lighting runs inside the map: %0d; reads of lit cells: %0d.",
                 runs_in_map, lit_reads);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Hard stop if the block hangs.
    initial begin : watchdog
        #12000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
